[src/bbpa_pkg.sv]
// shared types, codes and helpers for the block pool allocator
package bbpa_pkg;

   localparam int MAX_BLOCKS_DEF = 64;
   localparam logic [6:0] BLOCK_COUNT_RESET = 7'd64;

   // request actions
   localparam logic [2:0] ACT_ASSIGN = 3'd0;
   localparam logic [2:0] ACT_MARK   = 3'd1;
   localparam logic [2:0] ACT_RESET  = 3'd2;
   localparam logic [2:0] ACT_FORCE  = 3'd3;
   localparam logic [2:0] ACT_VICTIM = 3'd4;

   // block state codes
   localparam logic [2:0] BS_NATIVE    = 3'd0;
   localparam logic [2:0] BS_EXCLUSIVE = 3'd1;
   localparam logic [2:0] BS_SHARABLE  = 3'd2;
   localparam logic [2:0] BS_AVAILABLE = 3'd3;
   localparam logic [2:0] BS_INVALID   = 3'd4;

   // result status codes
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_NO_FREE = 2'd1;
   localparam logic [1:0] STS_BUSY    = 2'd2;
   localparam logic [1:0] STS_BAD     = 2'd3;

   typedef struct packed {
      logic [2:0] action;
      logic [2:0] init_state;
      logic [5:0] block_index;
   } req_type;

   typedef struct packed {
      logic [5:0] chosen_index;
      logic       found;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_LOOK,
      FSM_EVAL,
      FSM_SCAN,
      FSM_SWEEP,
      FSM_RESP
   } fsm_type;

   function automatic logic is_free(input logic [2:0] s);
      return (s == BS_AVAILABLE) || (s == BS_INVALID);
   endfunction

endpackage

[src/buffer_block_pool_allocator.sv]
// Block pool allocator: keeps one 3-bit state per block in a single-port-read
// memory and a serial fill pointer; each request gives exactly one response.
// Steps per request: assign on the serial path and mark-available read,
// evaluate and respond, and a rejected request goes straight to respond;
// assign past the fill pointer and select-victim scan the memory one block
// per cycle; force-reset-all sweeps n writes for a pool of n blocks; a
// checked reset-all scans and, if no block is busy, then sweeps. The memory
// takes one read and one write per cycle. After reset a clearing pass marks
// every one of the MAX_BLOCKS blocks invalid, and no request is taken until
// it ends. A result waiting in the response register does not hold off the
// next request. Write block_count only while no request is outstanding.
module buffer_block_pool_allocator import bbpa_pkg::*; #(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  req_type    req_data,
   output logic       req_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       rsp_stall,
   input  logic       csr_we,
   input  logic [6:0] csr_wdata
);

   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [2:0]    mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [2:0]    mem_rdata;
   logic          out_free;
   logic          res_load;
   rsp_type       res_data;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   bbpa_ctrl #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .out_free  (out_free),
      .res_load  (res_load),
      .res_data  (res_data)
   );

   bbpa_mem #(
      .DEPTH(MAX_BLOCKS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // response register: free when empty or being taken this cycle
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res_load || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = res_load ? res_data : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[src/bbpa_mem.sv]
// block state memory: one write port, one registered read port
module bbpa_mem import bbpa_pkg::*; #(
   parameter int DEPTH = MAX_BLOCKS_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [2:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [2:0]    rd_data
);

   logic [2:0] store_ff [DEPTH];
   logic [2:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bbpa_ctrl.sv]
// allocator sequencer: request decode, scans, sweeps and the count register
module bbpa_ctrl import bbpa_pkg::*; #(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
   localparam int CNTW = ($clog2(MAX_BLOCKS + 1) > 7) ? $clog2(MAX_BLOCKS + 1) : 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  req_type       req_data,
   output logic          req_stall,
   input  logic          csr_we,
   input  logic [6:0]    csr_wdata,
   output logic          mem_we,
   output logic [AW-1:0] mem_waddr,
   output logic [2:0]    mem_wdata,
   output logic [AW-1:0] mem_raddr,
   input  logic [2:0]    mem_rdata,
   input  logic          out_free,
   output logic          res_load,
   output rsp_type       res_data
);

   localparam logic [CNTW-1:0] MaxExt  = CNTW'(MAX_BLOCKS);
   localparam logic [CNTW-1:0] ClrLast = CNTW'(MAX_BLOCKS - 1);

   fsm_type         state_ff, state_in;
   logic [6:0]      block_count_ff, block_count_in;
   logic [2:0]      act_ff, act_in;
   logic [2:0]      sst_ff, sst_in;
   logic [5:0]      bidx_ff, bidx_in;
   logic [6:0]      ptr_ff, ptr_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            rd_vld_ff, rd_vld_in;
   logic [6:0]      rd_idx_ff, rd_idx_in;
   rsp_type         res_ff, res_in;

   logic [CNTW-1:0] bc_ext;
   logic [CNTW-1:0] n_eff;
   logic            accept;
   logic            req_bad;
   logic            ptr_in_range;
   logic            bidx_in_range;
   logic            scan_issue;
   logic            scan_match;
   logic            scan_hit;
   logic            scan_miss;
   logic            sweep_more;
   logic [6:0]      look_idx;

   // effective pool size
   assign bc_ext = CNTW'(block_count_ff);
   assign n_eff  = (bc_ext > MaxExt) ? MaxExt : bc_ext;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != FSM_IDLE);

   assign req_bad = (req_data.action > ACT_VICTIM) ||
                    ((req_data.action == ACT_ASSIGN) && (req_data.init_state >= BS_INVALID));
   assign ptr_in_range  = (CNTW'(ptr_ff) < n_eff);
   assign bidx_in_range = (CNTW'(req_data.block_index) < n_eff);

   // pipelined scan: one read issued per cycle, data checked in the following cycle
   assign scan_issue = (cnt_ff < n_eff);
   assign scan_match = (act_ff == ACT_RESET) ? !is_free(mem_rdata) : is_free(mem_rdata);
   assign scan_hit   = rd_vld_ff && scan_match;
   assign scan_miss  = !scan_hit && !scan_issue;
   assign sweep_more = (cnt_ff < n_eff);

   assign look_idx = (act_ff == ACT_ASSIGN) ? ptr_ff : {1'b0, bidx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= FSM_CLEAR;
         block_count_ff <= BLOCK_COUNT_RESET;
         ptr_ff         <= '0;
         cnt_ff         <= '0;
         rd_vld_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         block_count_ff <= block_count_in;
         ptr_ff         <= ptr_in;
         cnt_ff         <= cnt_in;
         rd_vld_ff      <= rd_vld_in;
      end
      act_ff    <= act_in;
      sst_ff    <= sst_in;
      bidx_ff   <= bidx_in;
      rd_idx_ff <= rd_idx_in;
      res_ff    <= res_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_CLEAR: begin
            if (cnt_ff == ClrLast) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (accept) begin
               priority if (req_bad) begin
                  state_in = FSM_RESP;
               end else if (req_data.action == ACT_ASSIGN) begin
                  state_in = ptr_in_range ? FSM_LOOK : FSM_SCAN;
               end else if (req_data.action == ACT_MARK) begin
                  state_in = bidx_in_range ? FSM_LOOK : FSM_RESP;
               end else if (req_data.action == ACT_FORCE) begin
                  state_in = FSM_SWEEP;
               end else begin
                  state_in = FSM_SCAN;
               end
            end
         end
         FSM_LOOK:  state_in = FSM_EVAL;
         FSM_EVAL:  state_in = FSM_RESP;
         FSM_SCAN: begin
            if (scan_hit) begin
               state_in = FSM_RESP;
            end else if (scan_miss) begin
               state_in = (act_ff == ACT_RESET) ? FSM_SWEEP : FSM_RESP;
            end
         end
         FSM_SWEEP: begin
            if (!sweep_more) begin
               state_in = FSM_RESP;
            end
         end
         FSM_RESP: begin
            if (out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default:   state_in = FSM_CLEAR;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      block_count_in = csr_we ? csr_wdata : block_count_ff;
      act_in    = act_ff;
      sst_in    = sst_ff;
      bidx_in   = bidx_ff;
      ptr_in    = ptr_ff;
      cnt_in    = cnt_ff;
      rd_vld_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_waddr = AW'(cnt_ff);
      mem_wdata = BS_AVAILABLE;
      mem_raddr = AW'(cnt_ff);
      res_load  = 1'b0;
      unique case (state_ff)
         FSM_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = BS_INVALID;
            cnt_in    = cnt_ff + 1'b1;
         end
         FSM_IDLE: begin
            if (accept) begin
               act_in  = req_data.action;
               sst_in  = req_data.init_state;
               bidx_in = req_data.block_index;
               cnt_in  = '0;
               res_in  = '{chosen_index: 6'd0, found: 1'b0, status: STS_OK};
               if (req_bad) begin
                  res_in.status = STS_BAD;
               end else if ((req_data.action == ACT_MARK) && !bidx_in_range) begin
                  res_in.status       = STS_BAD;
                  res_in.chosen_index = req_data.block_index;
               end
            end
         end
         FSM_LOOK: begin
            mem_raddr = AW'(look_idx);
         end
         FSM_EVAL: begin
            mem_waddr = AW'(look_idx);
            res_in.chosen_index = look_idx[5:0];
            if (act_ff == ACT_ASSIGN) begin
               if (!is_free(mem_rdata)) begin
                  res_in.status = STS_BUSY;
               end else begin
                  mem_we       = 1'b1;
                  mem_wdata    = sst_ff;
                  res_in.found = 1'b1;
                  ptr_in       = ptr_ff + 1'b1;
               end
            end else begin
               if (mem_rdata == BS_NATIVE) begin
                  res_in.status = STS_BAD;
               end else begin
                  mem_we = 1'b1;
               end
            end
         end
         FSM_SCAN: begin
            if (scan_issue) begin
               rd_vld_in = 1'b1;
               rd_idx_in = 7'(cnt_ff);
               cnt_in    = cnt_ff + 1'b1;
            end
            mem_waddr = AW'(rd_idx_ff);
            if (scan_hit) begin
               res_in.chosen_index = rd_idx_ff[5:0];
               if (act_ff == ACT_RESET) begin
                  res_in.status = STS_BUSY;
               end else begin
                  mem_we       = 1'b1;
                  mem_wdata    = (act_ff == ACT_ASSIGN) ? sst_ff : BS_INVALID;
                  res_in.found = 1'b1;
               end
            end else if (scan_miss) begin
               cnt_in = '0;
               if (act_ff != ACT_RESET) begin
                  res_in.status = STS_NO_FREE;
               end
            end
         end
         FSM_SWEEP: begin
            if (sweep_more) begin
               mem_we = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               ptr_in = '0;
            end
         end
         FSM_RESP: begin
            res_load = out_free;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   assign res_data = res_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != FSM_IDLE))
      else $error("request transfer did not start an operation");

   a_write_in_work_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == FSM_CLEAR || state_ff == FSM_EVAL ||
                  state_ff == FSM_SCAN || state_ff == FSM_SWEEP))
      else $error("memory write outside a working state");

   a_load_in_resp: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (state_ff == FSM_RESP && out_free))
      else $error("result loaded outside the response state");

   a_ptr_moves_legally: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (ptr_ff != $past(ptr_ff))) |->
         ($past(state_ff) == FSM_EVAL || $past(state_ff) == FSM_SWEEP))
      else $error("fill pointer changed outside assign or reset sweep");

endmodule
